// ===== rtl/rse_pkg.sv =====
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types and constants for the postfix stack evaluator: token kinds,
// status codes, operator bytes and the queue word between front and back.
// ----------------------------------------------------------------------------
package rse_pkg;

  // data path width of one stack entry
  localparam int DATA_W = 32;

  // default number of stack entries
  localparam int DEF_STACK_DEPTH = 256;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // action codes on the input side
  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_APPLY  = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  // operator bytes
  localparam logic [7:0] OP_ADD = 8'h2B;
  localparam logic [7:0] OP_SUB = 8'h2D;
  localparam logic [7:0] OP_MUL = 8'h2A;
  localparam logic [7:0] OP_DIV = 8'h2F;

  // result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_BADOP = 3'd2;
  localparam logic [2:0] ST_DEPTH = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;
  localparam logic [2:0] ST_DIV0  = 3'd5;

  // decoded token kind
  typedef enum logic [2:0] {
    K_PUSH,
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_BADOP,
    K_FINISH,
    K_NOP
  } kind_t;

  // one classified token as it waits in the queue
  typedef struct packed {
    kind_t             kind;
    logic [DATA_W-1:0] operand;
  } token_t;

  // handshake between the queue and the back end
  typedef struct packed {
    logic   valid;
    token_t token;
  } q_out_t;

endpackage

// ===== rtl/rse_front.sv =====
// ----------------------------------------------------------------------------
// rse_front
// Front end: takes input words and decodes action and operator byte into a
// single token kind for the back end.
// ----------------------------------------------------------------------------
module rse_front
  import rse_pkg::*;
(
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,   // operand_value [31:0], operator_char [39:32]
  input  logic [1:0]        in_tuser,   // action [1:0]
  input  logic              q_full,
  output logic              q_push,
  output token_t            q_token
);

  logic [7:0] op_char;
  kind_t      kind;

  assign op_char = in_tdata[39:32];

  // decode action and operator byte
  always_comb begin
    unique case (in_tuser)
      ACT_PUSH:   kind = K_PUSH;
      ACT_FINISH: kind = K_FINISH;
      ACT_APPLY: begin
        unique case (op_char)
          OP_ADD:  kind = K_ADD;
          OP_SUB:  kind = K_SUB;
          OP_MUL:  kind = K_MUL;
          OP_DIV:  kind = K_DIV;
          default: kind = K_BADOP;
        endcase
      end
      default:    kind = K_NOP;
    endcase
  end

  // accept whenever the queue has room
  assign in_tready       = !q_full;
  assign q_push          = in_tvalid && !q_full;
  assign q_token.kind    = kind;
  assign q_token.operand = in_tdata[DATA_W-1:0];

endmodule

// ===== rtl/rse_queue.sv =====
// ----------------------------------------------------------------------------
// rse_queue
// Short token queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rse_queue
  import rse_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  token_t push_token,
  output logic   full,
  input  logic   pop,
  output q_out_t q_out
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  token_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full        = (cnt_r == CW'(QUEUE_DEPTH));
  assign q_out.valid = (cnt_r != '0);
  assign q_out.token = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // token storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_token;
    end
  end

endmodule

// ===== rtl/rse_div.sv =====
// ----------------------------------------------------------------------------
// rse_div
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module rse_div
  import rse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int NW = $clog2(DATA_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] dividend_mag;
  logic [DATA_W-1:0] divisor_mag;

  // magnitudes of the operands
  assign dividend_mag = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
  assign divisor_mag  = divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;

  // one restoring step
  assign rem_sh = {rem_r, quo_r[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = NW'(DATA_W - 1);
      neg_nxt  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      rem_nxt  = '0;
      quo_nxt  = dividend_mag;
      dvs_nxt  = divisor_mag;
    end else if (busy_r) begin
      rem_nxt = diff[DATA_W] ? rem_sh[DATA_W-1:0] : diff[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], ~diff[DATA_W]};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  // sign fixup of the magnitude quotient
  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

// ===== rtl/rse_back.sv =====
// ----------------------------------------------------------------------------
// rse_back
// Back end: executes tokens on the stack. The top of stack sits in a
// register, the entries below it in a memory with a registered read port.
// ----------------------------------------------------------------------------
module rse_back
  import rse_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  q_out_t            q_out,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,   // value [31:0]
  output logic [2:0]        out_tuser,   // status [2:0]
  output logic              out_tlast    // done_res
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  kind_t             kind_r, kind_nxt;
  logic [DW-1:0]     depth_r, depth_nxt;
  logic [2:0]        err_r, err_nxt;
  logic [DATA_W-1:0] tos_r, tos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [2:0]        out_user_r, out_user_nxt;
  logic              out_last_r, out_last_nxt;

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [DW-1:0]     wr_idx;
  logic [DW-1:0]     rd_idx;
  logic              mem_we;

  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;
  logic [DATA_W-1:0] prod;
  logic [2:0]        emit_st;
  logic              fin;

  // entry below the top is at depth-2; old top goes to depth-1 on a push
  assign wr_idx = depth_r - 1'b1;
  assign rd_idx = depth_r - DW'(2);
  assign prod   = rd_data_r * tos_r;

  // stack memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[wr_idx[AW-1:0]] <= tos_r;
    end
    rd_data_r <= stack_mem[rd_idx[AW-1:0]];
  end

  rse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data_r),
    .divisor  (tos_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // status of the result being emitted
  assign fin     = (kind_r == K_FINISH);
  assign emit_st = (err_r != ST_OK) ? err_r :
                   (fin && depth_r != DW'(1)) ? ST_DEPTH : ST_OK;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    depth_nxt     = depth_r;
    err_nxt       = err_r;
    tos_nxt       = tos_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    div_start     = 1'b0;
    q_pop         = 1'b0;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_out.valid) begin
          q_pop     = 1'b1;
          kind_nxt  = q_out.token.kind;
          state_nxt = S_EMIT;
          priority if (q_out.token.kind == K_FINISH || q_out.token.kind == K_NOP ||
                       err_r != ST_OK) begin
            state_nxt = S_EMIT;
          end else if (q_out.token.kind == K_PUSH) begin
            if (depth_r == DW'(STACK_DEPTH)) begin
              err_nxt = ST_FULL;
            end else begin
              mem_we    = (depth_r != '0);
              tos_nxt   = q_out.token.operand;
              depth_nxt = depth_r + 1'b1;
            end
          end else if (depth_r < DW'(2)) begin
            err_nxt = ST_UNDER;
          end else if (q_out.token.kind == K_BADOP) begin
            err_nxt = ST_BADOP;
          end else begin
            state_nxt = S_READ;
          end
        end
      end

      // second operand is now in rd_data_r
      S_READ: begin
        state_nxt = S_EMIT;
        unique case (kind_r)
          K_ADD: begin
            tos_nxt   = rd_data_r + tos_r;
            depth_nxt = depth_r - 1'b1;
          end
          K_SUB: begin
            tos_nxt   = rd_data_r - tos_r;
            depth_nxt = depth_r - 1'b1;
          end
          K_MUL: begin
            tos_nxt   = prod;
            depth_nxt = depth_r - 1'b1;
          end
          K_DIV: begin
            if (tos_r == '0) begin
              err_nxt = ST_DIV0;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
          default: begin
            state_nxt = S_EMIT;
          end
        endcase
      end

      S_DIV: begin
        if (div_done) begin
          tos_nxt   = div_quo;
          depth_nxt = depth_r - 1'b1;
          state_nxt = S_EMIT;
        end
      end

      // load the output register once it is free
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = emit_st;
          out_last_nxt  = fin;
          out_data_nxt  = (emit_st == ST_OK && depth_r != '0) ? tos_r : '0;
          if (fin) begin
            depth_nxt = '0;
            err_nxt   = ST_OK;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r     <= kind_nxt;
    tos_r      <= tos_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/rpn_stack_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_top
// Postfix expression evaluator on a stack of signed 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one token per word. in_tuser holds the action (push, apply,
//           finish), in_tdata the operand and the operator byte.
//   out_* : exactly one result word per token. out_tuser is the status,
//           out_tdata the new top of stack (or the final value on finish,
//           zero on any error), out_tlast marks the result of a finish.
//   Each token runs through the sequencer states in order: push, finish and
//   tokens skipped under a latched error go from idle to emit; +, - and *
//   read the second operand first; / by nonzero also runs the divider, one
//   quotient bit per cycle (32 steps). A token is popped only in idle.
//   A two-word queue sits between the decoder and the execution sequencer,
//   so input is taken while a result waits in the output register.
//   Reset (rst_n low, synchronous) empties the stack, clears the error
//   latch and drops any queued token and pending result; stack memory is
//   not cleared. When out_tready is low the result holds, the sequencer
//   stops at its next result and input stalls once the queue is full.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_top
  import rse_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // operand_value [31:0], operator_char [39:32]
  input  logic [1:0]  in_tuser,    // action [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // value [31:0]
  output logic [2:0]  out_tuser,   // status [2:0]
  output logic        out_tlast    // done_res
);

  logic   q_full;
  logic   q_push;
  logic   q_pop;
  token_t q_token;
  q_out_t q_out;

  rse_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_token   (q_token)
  );

  rse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_token (q_token),
    .full       (q_full),
    .pop        (q_pop),
    .q_out      (q_out)
  );

  rse_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_out      (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/rse_checker.sv =====
// ----------------------------------------------------------------------------
// rse_checker
// Port-level checks on the result channel of the evaluator.
// ----------------------------------------------------------------------------
module rse_checker
  import rse_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // no result is pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // an error result carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("nonzero value with error status");

  // bad final depth is only reported at the end of an expression
  a_depth_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_DEPTH |-> out_tlast)
    else $error("bad depth status without last");

endmodule

bind rpn_stack_evaluator_top rse_checker u_rse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
